// ===== src/poa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package poa_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int TOTAL_BITS = 48;

    // Derived widths for the step-length datapath
    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int RAD_BITS  = 2 * MAG_BITS;
    localparam int ROOT_BITS = MAG_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int ITER_BITS = $clog2(ROOT_BITS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_pos;
        logic signed [COORD_BITS-1:0] y_pos;
        logic signed [COORD_BITS-1:0] depth;
    } poa_in_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_distance;
        logic [TOTAL_BITS-1:0] distance_at_depth;
    } poa_out_t;

    // One classified step, as handed from front to back
    typedef struct packed {
        logic                first;
        logic                deep;
        logic [MAG_BITS-1:0] mag_x;
        logic [MAG_BITS-1:0] mag_y;
    } poa_step_t;

    typedef struct packed {
        logic full;
        logic empty;
    } poa_q_status_t;

endpackage : poa_pkg

`default_nettype wire

// ===== src/poa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poa_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire poa_pkg::poa_in_t                     s_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic signed [poa_pkg::COORD_BITS-1:0] cfg_data,
    input  wire poa_pkg::poa_q_status_t               q_status,
    output logic                                      push,
    output poa_pkg::poa_step_t                        push_data
);
    import poa_pkg::*;

    logic                         first_reg;
    logic signed [COORD_BITS-1:0] last_x_reg;
    logic signed [COORD_BITS-1:0] last_y_reg;
    logic signed [COORD_BITS-1:0] thresh_reg;

    logic signed [MAG_BITS-1:0] diff_x;
    logic signed [MAG_BITS-1:0] diff_y;

    assign s_ready   = !q_status.full;
    assign cfg_ready = 1'b1;
    assign push      = s_valid && s_ready;

    assign diff_x = MAG_BITS'(s_data.x_pos) - MAG_BITS'(last_x_reg);
    assign diff_y = MAG_BITS'(s_data.y_pos) - MAG_BITS'(last_y_reg);

    always_comb begin
        push_data.first = first_reg;
        push_data.deep  = s_data.depth > thresh_reg;
        push_data.mag_x = diff_x[MAG_BITS-1] ? MAG_BITS'(-diff_x) : MAG_BITS'(diff_x);
        push_data.mag_y = diff_y[MAG_BITS-1] ? MAG_BITS'(-diff_y) : MAG_BITS'(diff_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= 1'b1;
            last_x_reg <= '0;
            last_y_reg <= '0;
            thresh_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            // record position for the next item
            if (push) begin
                first_reg  <= 1'b0;
                last_x_reg <= s_data.x_pos;
                last_y_reg <= s_data.y_pos;
            end
        end
    end

endmodule : poa_front

`default_nettype wire

// ===== src/poa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poa_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire poa_pkg::poa_step_t     push_data,
    input  wire logic                   pop,
    output poa_pkg::poa_step_t          pop_data,
    output poa_pkg::poa_q_status_t      q_status
);
    import poa_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    poa_step_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign q_status.full  = count_reg == CNT_BITS'(QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_data       = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : poa_queue

`default_nettype wire

// ===== src/poa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poa_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire poa_pkg::poa_q_status_t q_status,
    input  wire poa_pkg::poa_step_t     pop_data,
    output logic                        pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output poa_pkg::poa_out_t           m_data
);
    import poa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ADD,
        ST_ROOT,
        ST_ACC
    } state_t;

    state_t                state_reg;
    poa_step_t             step_reg;
    logic [RAD_BITS-1:0]   prod_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]   rem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [ITER_BITS-1:0]  iter_reg;
    logic [TOTAL_BITS-1:0] sum_reg;
    logic [TOTAL_BITS-1:0] deep_sum_reg;
    logic                  m_valid_reg;
    poa_out_t              m_data_reg;

    logic [MAG_BITS-1:0]   mul_in;
    logic [RAD_BITS-1:0]   mul_out;
    logic [REM_BITS-1:0]   rem_shift;
    logic [REM_BITS-1:0]   trial;
    logic                  root_ge;
    logic [TOTAL_BITS:0]   tot_wide;
    logic [TOTAL_BITS:0]   deep_wide;
    logic [TOTAL_BITS-1:0] sum_next;
    logic [TOTAL_BITS-1:0] deep_sum_next;
    logic                  out_free;

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // one shared squarer
    assign mul_in  = (state_reg == ST_SQ_X) ? step_reg.mag_x : step_reg.mag_y;
    assign mul_out = RAD_BITS'(mul_in) * RAD_BITS'(mul_in);

    // restoring square root, one result bit per cycle
    assign rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_ge   = rem_shift >= trial;

    // saturating accumulate
    assign tot_wide      = {1'b0, sum_reg} + (TOTAL_BITS+1)'(root_reg);
    assign deep_wide     = {1'b0, deep_sum_reg} + (TOTAL_BITS+1)'(root_reg);
    assign sum_next      = tot_wide[TOTAL_BITS] ? '1 : tot_wide[TOTAL_BITS-1:0];
    assign deep_sum_next = !step_reg.deep ? deep_sum_reg :
                           deep_wide[TOTAL_BITS] ? '1 : deep_wide[TOTAL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            deep_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        step_reg <= pop_data;
                        if (pop_data.first) begin
                            root_reg  <= '0;
                            state_reg <= ST_ACC;
                        end else begin
                            state_reg <= ST_SQ_X;
                        end
                    end
                end
                ST_SQ_X: begin
                    prod_reg  <= mul_out;
                    state_reg <= ST_SQ_Y;
                end
                ST_SQ_Y: begin
                    rad_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    rad_reg   <= rad_reg + prod_reg;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= ITER_BITS'(ROOT_BITS - 1);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    rem_reg  <= root_ge ? rem_shift - trial : rem_shift;
                    root_reg <= {root_reg[ROOT_BITS-2:0], root_ge};
                    rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // hold until the output register is free
                    if (out_free) begin
                        sum_reg                      <= sum_next;
                        deep_sum_reg                 <= deep_sum_next;
                        m_data_reg.total_distance    <= sum_next;
                        m_data_reg.distance_at_depth <= deep_sum_next;
                        m_valid_reg                  <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : poa_back

`default_nettype wire

// ===== src/path_odometry_accumulator_core.sv =====
// Path odometer core. Each input item carries the current position (x_pos, y_pos)
// and depth in signed Q16.8 metres; each accepted item yields exactly one result
// item with the running path length (total_distance) and the part of it travelled
// deeper than the configured threshold (distance_at_depth), both unsigned Q40.8
// and saturating at all ones. The first item after reset only records the
// position and reports the current totals. Later items add floor(sqrt(dx^2+dy^2))
// of the step from the previous position; the at-depth total also gets it when
// depth is strictly greater than the threshold (signed). The threshold is written
// through the cfg_ channel (always ready) and never clears the totals; write it
// only while the block is idle. Timing: the front takes an item in the cycle it is
// offered while the two-entry queue has room, so short bursts are absorbed. The
// back drains the queue one item at a time: pop, squaring dx then dy on the one
// shared 25x25 multiplier, one add, the bit-serial square root, one accumulate;
// the first item after reset goes from pop straight to the accumulate. That
// 25-step root loop sets the sustained rate. Results sit in an output register,
// so the back keeps working on the next item while a result waits for m_ready.
`timescale 1ns / 1ps
`default_nettype none

module path_odometry_accumulator_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // position items
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire poa_pkg::poa_in_t                      s_data,
    // totals
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output poa_pkg::poa_out_t                          m_data,
    // depth threshold write
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic signed [poa_pkg::COORD_BITS-1:0] cfg_data
);
    import poa_pkg::*;

    poa_q_status_t q_status;
    poa_step_t     push_data;
    poa_step_t     pop_data;
    logic          push;
    logic          pop;

    // Front: take items, difference against the last position, classify depth
    poa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: decouple intake from the long square-root work
    poa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Back: square, root, accumulate, present the totals
    poa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule : path_odometry_accumulator_core

`default_nettype wire

// ===== src/poa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module poa_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire poa_pkg::poa_out_t m_data
);
    import poa_pkg::*;

    logic [TOTAL_BITS-1:0] last_total_reg;

    // track the last delivered total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_total_reg <= '0;
        end else if (m_valid && m_ready) begin
            last_total_reg <= m_data.total_distance;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

    a_deep_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.distance_at_depth <= m_data.total_distance)
        else $error("at-depth distance exceeds total distance");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.total_distance >= last_total_reg)
        else $error("total distance decreased");

endmodule : poa_checker

bind path_odometry_accumulator_core poa_checker u_poa_checker (.*);

`default_nettype wire
